>>> sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros for the converter RTL.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SITOA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none

package sitoa_pkg;

    localparam int MaxDigits = 10;
    localparam int CntW      = $clog2(MaxDigits + 1);
    localparam int QDepth    = 2;
    localparam int QPtrW     = 1;
    localparam int QCntW     = 2;

    localparam logic [6:0]  AsciiZero  = 7'd48;
    localparam logic [6:0]  AsciiMinus = 7'd45;
    // floor(x / 10) == (x * RecipMul) >> RecipShift for every 32-bit x
    localparam logic [31:0] RecipMul   = 32'hCCCC_CCCD;
    localparam int          RecipShift = 35;

    typedef logic [MaxDigits-1:0][3:0] digit_buf_t;

    // One converted value: sign, digit count, digits least significant first
    typedef struct packed {
        logic             neg;
        logic [CntW-1:0]  ndig;
        digit_buf_t       digits;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// The front end stays busy after a start for one divide step per digit and one push,
// which waits while the queue is full; it takes a new value only once idle again.
// The back end fetches a value from the queue, then emits one character a cycle.
// The queue lets the front end convert the next value while the back end still emits.
// Reset clears the control state of all parts; the queue and digit buffers need no clearing.
// The receiver cannot stall: each character beat is shown for exactly one cycle.
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii import sitoa_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value,
    output logic                    char_strobe,
    output logic [6:0]              char_code,
    output logic                    last_char
);

    logic        push;
    logic        pop;
    entry_t      push_entry;
    entry_t      pop_entry;
    queue_stat_t qstat;

    // Front end: sign, magnitude, digit extraction
    sitoa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat)
    );

    // Queue between the two ends
    sitoa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (qstat)
    );

    // Back end: character emission
    sitoa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last_char   (last_char)
    );

    `SITOA_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !qstat.full, "push into full queue")
    `SITOA_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, !qstat.empty, "pop from empty queue")
    `SITOA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "not busy after start")
    `SITOA_ASSERT_SAME(a_minus_not_last, clk, rst_n, char_strobe && char_code == AsciiMinus, !last_char, "minus marked last")
    `SITOA_ASSERT_NEXT(a_digit_after_minus, clk, rst_n, char_strobe && char_code == AsciiMinus, char_strobe, "no digit after minus")

endmodule

`default_nettype wire

>>> sv/sitoa_front.sv
// Front end: takes a value, forms sign and magnitude, peels off decimal digits, and pushes the result into the queue.
`default_nettype none

module sitoa_front import sitoa_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] value,
    output logic                    busy,
    output logic                    push,
    output entry_t                  push_entry,
    input  wire queue_stat_t        qstat
);

    front_state_t state_reg, state_next;
    logic         neg_reg, neg_next;
    logic [31:0]  mag_reg, mag_next;
    logic [CntW-1:0] ndig_reg, ndig_next;
    digit_buf_t   digits_reg, digits_next;

    logic [63:0]  prod;
    logic [31:0]  quo;
    logic [31:0]  rem;
    logic [31:0]  val_u;

    // Divide by ten through the reciprocal
    assign val_u = value;
    assign prod  = 64'(mag_reg) * 64'(RecipMul);
    assign quo   = {3'b000, prod[63:RecipShift]};
    assign rem   = mag_reg - ((quo << 3) + (quo << 1));

    assign busy       = (state_reg != F_IDLE);
    assign push_entry = '{neg: neg_reg, ndig: ndig_reg, digits: digits_reg};

    // Next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        ndig_next   = ndig_reg;
        digits_next = digits_reg;
        push        = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    neg_next   = val_u[31];
                    mag_next   = val_u[31] ? (32'd0 - val_u) : val_u;
                    ndig_next  = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                if (ndig_reg < CntW'(MaxDigits))
                begin
                    digits_next[ndig_reg] = rem[3:0];
                end
                ndig_next = ndig_reg + CntW'(1);
                mag_next  = quo;
                if (quo == 32'd0 || ndig_reg == CntW'(MaxDigits - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!qstat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        ndig_reg   <= ndig_next;
        digits_reg <= digits_next;
    end

endmodule

`default_nettype wire

>>> sv/sitoa_queue.sv
// Two-entry queue of converted values between front and back end.
`default_nettype none

module sitoa_queue import sitoa_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      pop_entry,
    output queue_stat_t stat
);

    entry_t           mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == QCntW'(QDepth));
    assign stat.empty = (count_reg == '0);
    assign pop_entry  = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/sitoa_back.sv
// Back end: emits the sign and digits of one queued value, one beat a cycle.
`default_nettype none

module sitoa_back import sitoa_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire queue_stat_t qstat,
    input  wire entry_t      pop_entry,
    output logic             pop,
    output logic             char_strobe,
    output logic [6:0]       char_code,
    output logic             last_char
);

    back_state_t     state_reg, state_next;
    logic            sign_pend_reg, sign_pend_next;
    logic [CntW-1:0] idx_reg, idx_next;
    digit_buf_t      digits_reg, digits_next;
    logic            strobe_reg, strobe_next;
    logic [6:0]      code_reg, code_next;
    logic            last_reg, last_next;

    assign char_strobe = strobe_reg;
    assign char_code   = code_reg;
    assign last_char   = last_reg;

    // Sequencer: minus first if negative, then digits most significant first
    always_comb
    begin
        state_next     = state_reg;
        sign_pend_next = sign_pend_reg;
        idx_next       = idx_reg;
        digits_next    = digits_reg;
        strobe_next    = 1'b0;
        code_next      = code_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop            = 1'b1;
                    digits_next    = pop_entry.digits;
                    sign_pend_next = pop_entry.neg;
                    idx_next       = pop_entry.ndig - CntW'(1);
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                strobe_next = 1'b1;
                if (sign_pend_reg)
                begin
                    code_next      = AsciiMinus;
                    last_next      = 1'b0;
                    sign_pend_next = 1'b0;
                end
                else
                begin
                    code_next = AsciiZero + {3'b000, digits_reg[idx_reg]};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - CntW'(1);
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sign_pend_reg <= sign_pend_next;
        idx_reg       <= idx_next;
        digits_reg    <= digits_next;
        code_reg      <= code_next;
        last_reg      <= last_next;
    end

endmodule

`default_nettype wire

>>> sim/signed_int_to_decimal_ascii_test.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`default_nettype none

module signed_int_to_decimal_ascii_test;
    import sitoa_pkg::*;

    typedef struct {
        logic [31:0] val;
        int          idle_pct;   // chance in 100 that the sender idles a cycle
        bit          drain;      // hold off until every expected character has come and busy is low
    } pending_value_t;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } char_beat_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] value;
    logic               char_strobe;
    logic [6:0]         char_code;
    logic               last_char;

    pending_value_t pending_values[$];
    char_beat_t     expected_chars[$];
    logic           taken;
    int             values_sent;
    int             negatives_sent;
    int             chars_checked;
    int             mismatches;

    signed_int_to_decimal_ascii uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last_char   (last_char)
    );

    // Expected characters of one value: optional minus, then digits most significant first
    function automatic void push_decimal_chars(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digits [10];
        int          ndig;
        char_beat_t  beat;
        // magnitude in unsigned arithmetic so the most negative value is exact
        mag = v[31] ? (32'd0 - v) : v;
        ndig = 0;
        do
        begin
            digits[ndig] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            ndig++;
        end
        while (mag != 32'd0);
        if (v[31])
        begin
            beat.code = AsciiMinus;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            beat.code = AsciiZero + 7'(digits[k]);
            beat.last = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Random value, usually with a random digit count, so short and long strings both show up
    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        if ($urandom_range(7) == 0)
            return $urandom;
        n = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo *= 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483648)
            hi = 64'd2147483648;
        if (n == 1)
            lo = 0;
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        if (mag == 64'd2147483648 || $urandom_range(1) == 1)
            return 32'(-mag);
        return 32'(mag);
    endfunction

    function automatic void add_value(input logic [31:0] v, input int pct, input bit drain);
        pending_value_t item;
        item.val      = v;
        item.idle_pct = pct;
        item.drain    = drain;
        pending_values.push_back(item);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Limit on the whole run
    initial
    begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end

    // Driver: new beat at the falling edge once the previous one was taken
    always @(negedge clk)
    begin : driver
        bit go;
        if (rst_n && (!start || taken))
        begin
            go = 1'b0;
            if (pending_values.size() != 0)
            begin
                if (pending_values[0].drain && (expected_chars.size() != 0 || busy))
                    go = 1'b0;
                else
                    go = ($urandom_range(99) >= pending_values[0].idle_pct);
            end
            if (go)
            begin
                start <= 1'b1;
                value <= pending_values[0].val;
                pending_values.pop_front();
            end
            else
            begin
                // garbage on value while idle must be ignored
                start <= 1'b0;
                value <= $urandom;
            end
        end
    end

    // Monitor: predict on accepted values, check every character beat
    always @(posedge clk)
    begin : monitor
        char_beat_t exp_beat;
        if (rst_n && char_strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character: code %0d last %0b", char_code, last_char);
            end
            else
            begin
                exp_beat = expected_chars.pop_front();
                chars_checked++;
                if (char_code !== exp_beat.code || last_char !== exp_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                                 exp_beat.code, exp_beat.last, char_code, last_char);
                end
            end
        end
        taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            push_decimal_chars(value);
            values_sent++;
            if (value[31])
                negatives_sent++;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int pcts [3];
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        taken          = 1'b0;
        values_sent    = 0;
        negatives_sent = 0;
        chars_checked  = 0;
        mismatches     = 0;
        pcts = '{59, 0, 19};

        // directed: zero, extremes, digit-count boundaries, bit patterns
        add_value(32'd0, 0, 1'b0);
        add_value(32'd1, 0, 1'b0);
        add_value(-32'sd1, 0, 1'b0);
        add_value(32'd9, 0, 1'b0);
        add_value(32'd10, 0, 1'b0);
        add_value(-32'sd10, 0, 1'b0);
        add_value(32'd99, 0, 1'b0);
        add_value(32'd100, 0, 1'b0);
        add_value(32'h7FFF_FFFF, 0, 1'b0);
        add_value(32'h8000_0000, 0, 1'b0);
        add_value(32'h8000_0001, 0, 1'b0);
        add_value(32'd1000000000, 0, 1'b0);
        add_value(32'd999999999, 0, 1'b0);
        add_value(-32'sd999999999, 0, 1'b0);
        add_value(-32'sd1000000000, 0, 1'b0);
        add_value(32'd1000000009, 0, 1'b0);
        add_value(32'd123456789, 0, 1'b0);
        add_value(-32'sd5, 0, 1'b0);
        add_value(32'h5555_5555, 0, 1'b0);
        add_value(32'hAAAA_AAAA, 0, 1'b0);
        add_value(32'h8000_0000, 0, 1'b0);
        add_value(32'd0, 0, 1'b0);

        // random values in three idle phases, each opening with a full drain
        for (int p = 0; p < 3; p++)
            for (int i = 0; i < 120; i++)
                add_value(random_value(), pcts[p],
                          (i == 0) || ($urandom_range(39) == 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_values.size() != 0 || start || expected_chars.size() != 0)
            @(posedge clk);
        // catch any stray characters after the last expected one
        repeat (40) @(posedge clk);

        $display("converted %0d values (%0d negative), checked %0d characters",
                 values_sent, negatives_sent, chars_checked);
        $display("sender idle phases: none, 59 and 19 in 100; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
